// ----- sv/swpu_pkg.sv -----
package swpu_pkg;

	// request selector codes
	typedef enum logic [2:0] {
		FN_STDP   = 3'd0,
		FN_BCM    = 3'd1,
		FN_HEBB   = 3'd2,
		FN_ANTI   = 3'd3,
		FN_HOMEO  = 3'd4,
		FN_DECAY  = 3'd5,
		FN_LOAD   = 3'd6,
		FN_UNUSED = 3'd7
	} func_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_LEARNING_RATE  = 3'd0,
		REG_GAIN_UP        = 3'd1,
		REG_GAIN_DOWN      = 3'd2,
		REG_TAU_PRE        = 3'd3,
		REG_TAU_POST       = 3'd4,
		REG_ACT_THRESHOLD  = 3'd5,
		REG_WEIGHT_MIN     = 3'd6,
		REG_WEIGHT_MAX     = 3'd7
	} reg_idx_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_EXP,
		ST_MUL,
		ST_ACC,
		ST_FIN
	} state_t;

	localparam logic signed [31:0] ONE_Q       = 32'sd65536;
	localparam logic [12:0]        STDP_WINDOW = 13'd6554;
	localparam int                 MAG_W       = 13;
	localparam int                 QUOT_W      = MAG_W + 16;
	localparam int                 TAU_W       = 31;
	localparam int                 EXP_W       = 17;

	// saturate a 33-bit sum to 32-bit signed
	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v > 33'sh0_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -33'sh0_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ----- sv/swpu_div.sv -----
module swpu_div import swpu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MAG_W-1:0]    mag,
	input  logic [TAU_W-1:0]    tau,
	output logic                done,
	output logic [QUOT_W-1:0]   quot
);

	localparam int CNT_W = $clog2(QUOT_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic [QUOT_W-1:0] dvd_q;
	logic [TAU_W-1:0]  dvs_q;
	logic [TAU_W:0]    rem_q;
	logic [TAU_W:0]    trial;
	logic              fit;

	// one quotient bit per cycle, restoring
	always_comb begin
		trial = {rem_q[TAU_W-1:0], dvd_q[QUOT_W-1]};
		fit   = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(QUOT_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {mag, 16'd0};
			dvs_q <= (tau == '0) ? TAU_W'(1) : tau;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fit ? (trial - {1'b0, dvs_q}) : trial;
			dvd_q <= {dvd_q[QUOT_W-2:0], fit};
		end
	end

	assign done = (cnt_q == '0);
	assign quot = dvd_q;

endmodule

// ----- sv/swpu_mul.sv -----
module swpu_mul import swpu_pkg::*; (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [31:0] res
);

	logic signed [65:0] prod_s1;
	logic signed [65:0] adj;
	logic signed [49:0] q;

	// product register
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	// q16.16 rescale truncating toward zero, then saturate
	always_comb begin
		adj = prod_s1 + (prod_s1[65] ? 66'sd65535 : 66'sd0);
		q   = 50'(adj >>> 16);
		if (q > 50'sh0_7FFF_FFFF)
			res = 32'sh7FFF_FFFF;
		else if (q < -50'sh0_8000_0000)
			res = 32'sh8000_0000;
		else
			res = q[31:0];
	end

endmodule

// ----- sv/swpu_exp.sv -----
module swpu_exp import swpu_pkg::*; #(
	parameter int N = 256
) (
	input  logic [QUOT_W-1:0] x,
	output logic [EXP_W-1:0]  e
);

	localparam int TW = $clog2(N + 1);
	localparam logic [63:0] Q30 = 64'd1073741824;
	localparam logic [63:0] STEP_Q30 = (64'd8 * 64'd1073741824) / N;

	typedef logic [EXP_W-1:0] tab_t [0:N];

	// exp(-k*8/N) table, built at elaboration
	function automatic tab_t build_tab();
		tab_t t;
		logic [63:0] term;
		logic [63:0] v;
		logic [63:0] r;
		logic signed [63:0] sum;
		term = Q30;
		sum  = $signed(Q30);
		v    = Q30;
		for (int i = 1; i <= 16; i++) begin
			term = ((term * STEP_Q30) >> 30) / 64'(i);
			if (i % 2 == 1)
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		r = $unsigned(sum);
		t[0] = EXP_W'(65536);
		for (int k = 1; k <= N; k++) begin
			v = (v * r) >> 30;
			t[k] = EXP_W'((v + 64'd8192) >> 14);
		end
		return t;
	endfunction

	localparam tab_t TAB = build_tab();

	logic            big;
	logic [31:0]     prod;
	logic [28:0]     pos;
	logic [TW-1:0]   idx;
	logic [TW-1:0]   idx_n;
	logic [15:0]     frac;
	logic [EXP_W-1:0] ea;
	logic [EXP_W-1:0] eb;
	logic [EXP_W-1:0] diff;
	logic [32:0]     corr;

	// table position and linear interpolation
	always_comb begin
		big   = |x[QUOT_W-1:19];
		prod  = {13'd0, x[18:0]} * 32'(N);
		pos   = prod[31:3];
		idx   = pos[16 +: TW];
		idx_n = idx + 1'b1;
		frac  = pos[15:0];
		ea    = TAB[idx];
		eb    = TAB[idx_n];
		diff  = ea - eb;
		corr  = diff * frac;
		e     = big ? TAB[N] : (ea - corr[32:16]);
	end

endmodule

// ----- sv/synapse_weight_plasticity_update_unit.sv -----
// sequence: load and skipped requests go straight to the result; hebbian, homeostatic
// and decay run their multiply and accumulate steps, bcm one more such step, stdp a
// bit-serial divide with a done check, then exp and two multiplies
// throughput: one request at a time; the next is taken once the result is registered
// all products go through one shared 33x33 multiplier
// reset: asynchronous active low; weight returns to 1.0, registers to their defaults
module synapse_weight_plasticity_update_unit import swpu_pkg::*; #(
	parameter int EXP_TABLE_ENTRIES = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// func, pre spike time, post spike time, pre rate, post rate,
	// target rate, measured rate, decay factor, time_step, new_weight, zero pad
	input  logic [295:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// weight_out, weight_delta, applied, zero pad
	output logic [71:0]  m_axis_tdata
);

	state_t state_q, state_d;

	logic [30:0]        lr_q, gain_up_q, gain_dn_q, tau_pre_q, tau_post_q;
	logic signed [31:0] thr_q, wmin_q, wmax_q, weight_q;

	logic [2:0]         func_q;
	logic               active_q, dt_pos_q;
	logic [1:0]         step_q;
	logic signed [31:0] pre_a_q, post_a_q, tgt_q, act_q, drate_q, nw_q;
	logic [30:0]        tstep_q;
	logic signed [31:0] acc_q, delta_q;
	logic [EXP_W-1:0]   e_q;

	logic               out_valid_q, out_applied_q;
	logic signed [31:0] out_weight_q, out_delta_q;

	// input fields
	logic [2:0]         in_func;
	logic signed [31:0] in_pre_t, in_post_t, in_drate;
	logic signed [32:0] dt, mag;
	logic               in_win, in_active, accept, fire;

	logic               div_start, div_done;
	logic [QUOT_W-1:0]  quot;
	logic [EXP_W-1:0]   e_val;
	logic signed [32:0] mul_a, mul_b;
	logic signed [31:0] mul_res;
	logic [1:0]         last_step;

	logic signed [31:0] fin_delta, fin_add, fin_sum, fin_clip, fin_w;
	logic               fin_applied;

	assign in_func   = s_axis_tdata[2:0];
	assign in_pre_t  = s_axis_tdata[34:3];
	assign in_post_t = s_axis_tdata[66:35];
	assign in_drate  = s_axis_tdata[226:195];
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign fire      = !out_valid_q || m_axis_tready;

	// spike pair and window check at the input
	always_comb begin
		dt     = {in_post_t[31], in_post_t} - {in_pre_t[31], in_pre_t};
		mag    = dt[32] ? -dt : dt;
		in_win = !in_pre_t[31] && !in_post_t[31] && (mag < 33'(STDP_WINDOW));
		case (in_func)
			FN_STDP:   in_active = in_win;
			FN_DECAY:  in_active = !in_drate[31] && (in_drate != '0);
			FN_UNUSED: in_active = 1'b0;
			default:   in_active = 1'b1;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q       <= 31'd655;
			gain_up_q  <= 31'd6554;
			gain_dn_q  <= 31'd7864;
			tau_pre_q  <= 31'd1310720;
			tau_post_q <= 31'd1310720;
			thr_q      <= 32'sd65536;
			wmin_q     <= 32'sd0;
			wmax_q     <= 32'sd655360;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_LEARNING_RATE: lr_q       <= cfg_wdata[30:0];
				REG_GAIN_UP:       gain_up_q  <= cfg_wdata[30:0];
				REG_GAIN_DOWN:     gain_dn_q  <= cfg_wdata[30:0];
				REG_TAU_PRE:       tau_pre_q  <= cfg_wdata[30:0];
				REG_TAU_POST:      tau_post_q <= cfg_wdata[30:0];
				REG_ACT_THRESHOLD: thr_q      <= cfg_wdata;
				REG_WEIGHT_MIN:    wmin_q     <= cfg_wdata;
				REG_WEIGHT_MAX:    wmax_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// arithmetic units
	swpu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (mag[MAG_W-1:0]),
		.tau    (dt[32] || dt == '0 ? tau_post_q : tau_pre_q),
		.done   (div_done),
		.quot   (quot)
	);

	swpu_exp #(.N(EXP_TABLE_ENTRIES)) u_exp (
		.x (quot),
		.e (e_val)
	);

	swpu_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.res (mul_res)
	);

	assign last_step = (func_q == FN_BCM) ? 2'd2 : 2'd1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_func == FN_STDP && in_active)
						state_d = ST_DIV;
					else if ((in_func == FN_DECAY && in_active) || in_func == FN_BCM
						|| in_func == FN_HEBB || in_func == FN_ANTI || in_func == FN_HOMEO)
						state_d = ST_MUL;
					else
						state_d = ST_FIN;
				end
			end
			ST_DIV:  if (div_done) state_d = ST_EXP;
			ST_EXP:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_ACC;
			ST_ACC:  state_d = (step_q == last_step) ? ST_FIN : ST_MUL;
			ST_FIN:  if (fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		div_start     = accept && (in_func == FN_STDP) && in_active;
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (func_q)
			FN_STDP: begin
				if (step_q == 2'd0) begin
					mul_a = {2'b00, dt_pos_q ? gain_up_q : gain_dn_q};
					mul_b = 33'({1'b0, e_q});
				end else begin
					mul_a = {2'b00, lr_q};
					mul_b = {delta_q[31], delta_q};
				end
			end
			FN_BCM, FN_HEBB, FN_ANTI: begin
				if (step_q == 2'd0) begin
					mul_a = {2'b00, lr_q};
					mul_b = {pre_a_q[31], pre_a_q};
				end else if (step_q == 2'd1) begin
					mul_a = {acc_q[31], acc_q};
					mul_b = {post_a_q[31], post_a_q};
				end else begin
					mul_a = {acc_q[31], acc_q};
					mul_b = {1'b0, sat32({post_a_q[31], post_a_q} - {thr_q[31], thr_q})};
					mul_b[32] = mul_b[31];
				end
			end
			FN_HOMEO: begin
				if (step_q == 2'd0) begin
					mul_a = {2'b00, lr_q};
					mul_b = {1'b0, sat32({tgt_q[31], tgt_q} - {act_q[31], act_q})};
					mul_b[32] = mul_b[31];
				end else begin
					mul_a = {acc_q[31], acc_q};
					mul_b = {weight_q[31], weight_q};
				end
			end
			FN_DECAY: begin
				if (step_q == 2'd0) begin
					mul_a = {drate_q[31], drate_q};
					mul_b = {2'b00, tstep_q};
				end else begin
					mul_a = {weight_q[31], weight_q};
					mul_b = {1'b0, sat32({ONE_Q[31], ONE_Q} - {acc_q[31], acc_q})};
					mul_b[32] = mul_b[31];
				end
			end
			default: ;
		endcase
	end

	// final weight and reported change
	always_comb begin
		fin_delta   = acc_q;
		fin_add     = acc_q;
		fin_applied = 1'b1;
		case (func_q)
			FN_STDP:  fin_delta = delta_q;
			FN_ANTI:  begin
				fin_delta = sat32(-{acc_q[31], acc_q});
				fin_add   = fin_delta;
			end
			FN_DECAY: fin_delta = sat32({acc_q[31], acc_q} - {weight_q[31], weight_q});
			default: ;
		endcase
		fin_sum  = sat32({weight_q[31], weight_q} + {fin_add[31], fin_add});
		fin_clip = (fin_sum > wmax_q) ? wmax_q : fin_sum;
		fin_clip = (fin_clip < wmin_q) ? wmin_q : fin_clip;
		fin_w    = fin_clip;
		case (func_q)
			FN_DECAY: fin_w = (acc_q < wmin_q) ? wmin_q : acc_q;
			FN_LOAD:  begin
				fin_w     = nw_q;
				fin_delta = '0;
			end
			default: ;
		endcase
		if (!active_q) begin
			fin_w       = weight_q;
			fin_delta   = '0;
			fin_applied = 1'b0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			weight_q    <= ONE_Q;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				step_q <= '0;
			else if (state_q == ST_ACC)
				step_q <= step_q + 1'b1;
			if (state_q == ST_FIN && fire) begin
				weight_q    <= fin_w;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= in_func;
			active_q <= in_active;
			dt_pos_q <= !dt[32] && (dt != '0);
			pre_a_q  <= s_axis_tdata[98:67];
			post_a_q <= s_axis_tdata[130:99];
			tgt_q    <= s_axis_tdata[162:131];
			act_q    <= s_axis_tdata[194:163];
			drate_q  <= in_drate;
			tstep_q  <= s_axis_tdata[257:227];
			nw_q     <= s_axis_tdata[289:258];
		end
		if (state_q == ST_EXP)
			e_q <= e_val;
		if (state_q == ST_ACC) begin
			acc_q <= mul_res;
			if (func_q == FN_STDP && step_q == 2'd0)
				delta_q <= dt_pos_q ? mul_res : -mul_res;
		end
		if (state_q == ST_FIN && fire) begin
			out_weight_q  <= fin_w;
			out_delta_q   <= fin_delta;
			out_applied_q <= fin_applied;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_applied_q, out_delta_q, out_weight_q};

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("request taken while busy");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !div_done) |=> state_q == ST_DIV)
		else $error("left divide before quotient ready");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_weight_q)))
		else $error("pending result overwritten");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import swpu_pkg::*;

	localparam longint Q_ONE = 65536;
	localparam longint WINDOW = 6554;
	localparam int LUT_N = 256;
	localparam int DRAIN_CYCLES = 60;

	// one update request
	typedef struct {
		logic [2:0]         fn;
		logic signed [31:0] pre_t;
		logic signed [31:0] post_t;
		logic signed [31:0] pre_a;
		logic signed [31:0] post_a;
		logic signed [31:0] target;
		logic signed [31:0] actual;
		logic signed [31:0] drate;
		logic [30:0]        tstep;
		logic signed [31:0] load_w;
	} request_t;

	// one weight report
	typedef struct {
		logic signed [31:0] w_out;
		logic signed [31:0] w_delta;
		logic               upd;
	} weight_rep_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_addr = '0;
	logic [31:0]  cfg_wdata = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// func, pre spike time, post spike time, pre rate, post rate,
	// target rate, measured rate, decay factor, time_step, new_weight, zero pad
	logic [295:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// weight_out, weight_delta, applied, zero pad
	logic [71:0]  m_axis_tdata;

	synapse_weight_plasticity_update_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow copy of the weight and the registers
	longint syn_weight = 65536;
	longint lrate = 655, gain_up = 6554, gain_down = 7864;
	longint tau_up = 1310720, tau_down = 1310720;
	longint bcm_thr = 65536, w_floor = 0, w_ceil = 655360;
	longint unsigned exp_lut [0:LUT_N];

	weight_rep_t expected_reps [$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int tx_idle = 0;
	int rx_idle = 0;
	int rx_hold = 0;

	function automatic longint sat(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return sat((a * b) / Q_ONE);
	endfunction

	function automatic longint bound_weight(longint w);
		if (w > w_ceil) w = w_ceil;
		if (w < w_floor) w = w_floor;
		return w;
	endfunction

	// exp(-k*8/N) in Q16.16 from a Q2.30 series and repeated products
	function automatic void fill_exp_lut();
		longint unsigned h, term, ratio, v;
		longint acc;
		h = (64'd8 << 30) / LUT_N;
		term = 64'd1 << 30;
		acc = 64'sd1 << 30;
		v = 64'd1 << 30;
		for (int i = 1; i <= 16; i++) begin
			term = ((term * h) >> 30) / i;
			if (i % 2 == 1) acc = acc - longint'(term);
			else acc = acc + longint'(term);
		end
		ratio = longint'(acc);
		exp_lut[0] = Q_ONE;
		for (int i = 1; i <= LUT_N; i++) begin
			v = (v * ratio) >> 30;
			exp_lut[i] = ((v + 64'd8192) >> 14) & 64'hFFFF_FFFF;
		end
	endfunction

	function automatic longint exp_decay(longint unsigned x);
		longint unsigned pos, idx, frac, a, b;
		if (x >= (64'd8 << 16)) return longint'(exp_lut[LUT_N]);
		pos = (x * LUT_N) / 8;
		idx = pos >> 16;
		frac = pos & 64'hFFFF;
		if (idx >= LUT_N) return longint'(exp_lut[LUT_N]);
		a = exp_lut[idx];
		b = exp_lut[idx + 1];
		return longint'(a - (((a - b) * frac) >> 16));
	endfunction

	// expected report for one request, advancing the shadow weight
	function automatic weight_rep_t plasticity_step(request_t r);
		weight_rep_t rep;
		longint dlt, dt, tau, e, fac, w;
		longint unsigned mag;
		bit upd;
		dlt = 0;
		upd = 1'b0;
		case (r.fn)
			FN_STDP: begin
				if (r.pre_t >= 0 && r.post_t >= 0) begin
					dt = longint'(r.post_t) - longint'(r.pre_t);
					mag = (dt < 0) ? -dt : dt;
					if (mag < WINDOW) begin
						tau = (dt > 0) ? tau_up : tau_down;
						if (tau < 1) tau = 1;
						e = exp_decay((mag << 16) / tau);
						if (dt > 0) dlt = qmul(gain_up, e);
						else dlt = -qmul(gain_down, e);
						syn_weight = bound_weight(sat(syn_weight + qmul(lrate, dlt)));
						upd = 1'b1;
					end
				end
			end
			FN_BCM: begin
				dlt = qmul(qmul(qmul(lrate, r.pre_a), r.post_a),
					sat(longint'(r.post_a) - bcm_thr));
				syn_weight = bound_weight(sat(syn_weight + dlt));
				upd = 1'b1;
			end
			FN_HEBB, FN_ANTI: begin
				dlt = qmul(qmul(lrate, r.pre_a), r.post_a);
				if (r.fn == FN_ANTI) dlt = sat(-dlt);
				syn_weight = bound_weight(sat(syn_weight + dlt));
				upd = 1'b1;
			end
			FN_HOMEO: begin
				dlt = qmul(qmul(lrate, sat(longint'(r.target) - longint'(r.actual))),
					syn_weight);
				syn_weight = bound_weight(sat(syn_weight + dlt));
				upd = 1'b1;
			end
			FN_DECAY: begin
				if (r.drate > 0) begin
					fac = sat(Q_ONE - qmul(r.drate, longint'({1'b0, r.tstep})));
					w = qmul(syn_weight, fac);
					dlt = sat(w - syn_weight);
					syn_weight = (w < w_floor) ? w_floor : w;
					upd = 1'b1;
				end
			end
			FN_LOAD: begin
				syn_weight = r.load_w;
				upd = 1'b1;
			end
			default: ;
		endcase
		rep.w_out = syn_weight[31:0];
		rep.w_delta = dlt[31:0];
		rep.upd = upd;
		return rep;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// predict on every accepted request
	always @(posedge clk) begin
		request_t r;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			r.fn = s_axis_tdata[2:0];
			r.pre_t = s_axis_tdata[34:3];
			r.post_t = s_axis_tdata[66:35];
			r.pre_a = s_axis_tdata[98:67];
			r.post_a = s_axis_tdata[130:99];
			r.target = s_axis_tdata[162:131];
			r.actual = s_axis_tdata[194:163];
			r.drate = s_axis_tdata[226:195];
			r.tstep = s_axis_tdata[257:227];
			r.load_w = s_axis_tdata[289:258];
			expected_reps = {expected_reps, plasticity_step(r)};
		end
	end

	// compare every accepted report with the oldest prediction
	always @(posedge clk) begin
		weight_rep_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_reps.size() == 0) begin
				errors++;
				$display("[%0t] report with no request outstanding", $realtime);
			end else begin
				want = expected_reps.pop_front();
				n_checked++;
				if ($signed(m_axis_tdata[31:0]) != want.w_out)
					report_mismatch("weight_out", $signed(m_axis_tdata[31:0]), want.w_out);
				if ($signed(m_axis_tdata[63:32]) != want.w_delta)
					report_mismatch("weight_delta", $signed(m_axis_tdata[63:32]),
						want.w_delta);
				if (m_axis_tdata[64] != want.upd)
					report_mismatch("applied", m_axis_tdata[64], want.upd);
			end
		end
	end

	// receiver readiness, with an optional long hold-off
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold = rx_hold - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	task automatic send_request(input request_t r);
		if ($urandom_range(99) < tx_idle) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, r.load_w, r.tstep, r.drate, r.actual, r.target,
			r.post_a, r.pre_a, r.post_t, r.pre_t, r.fn};
		do @(posedge clk); while (!s_axis_tready);
		n_sent++;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_reps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		longint u31, s32;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		u31 = longint'({1'b0, val[30:0]});
		s32 = longint'($signed(val));
		case (idx)
			REG_LEARNING_RATE: lrate = u31;
			REG_GAIN_UP:       gain_up = u31;
			REG_GAIN_DOWN:     gain_down = u31;
			REG_TAU_PRE:       tau_up = u31;
			REG_TAU_POST:      tau_down = u31;
			REG_ACT_THRESHOLD: bcm_thr = s32;
			REG_WEIGHT_MIN:    w_floor = s32;
			REG_WEIGHT_MAX:    w_ceil = s32;
			default: ;
		endcase
	endtask

	// register sets, the extremes among them
	task automatic apply_setting(input int k);
		logic [31:0] v [8];
		case (k % 6)
			0: v = '{655, 6554, 7864, 1310720, 1310720, 65536, 0, 655360};
			1: v = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0,
				32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
			2: v = '{0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
				32'h8000_0000, 32'h0005_0000, 32'h0002_0000};
			3: v = '{$urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom};
			4: v = '{$urandom_range(1, 32'h0004_0000), $urandom_range(0, 32'h0002_0000),
				$urandom_range(0, 32'h0002_0000), $urandom_range(1, 32'h0000_4000),
				$urandom_range(1, 32'h0000_4000), $urandom_range(0, 32'h0004_0000),
				-$urandom_range(0, 32'h0008_0000), $urandom_range(0, 32'h0010_0000)};
			default: v = '{$urandom_range(0, 32'h0001_0000), 32'h8001_0000, 32'h8000_8000,
				$urandom_range(1, 32'h0040_0000), $urandom_range(1, 32'h0040_0000),
				-$urandom_range(0, 32'h0002_0000), -32'h000A_0000, 32'h000A_0000};
		endcase
		for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), v[i]);
	endtask

	function automatic logic [31:0] any_value();
		if ($urandom_range(1)) return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
		return $urandom;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int pick;
		logic [31:0] base;
		r.pre_a = any_value();
		r.post_a = any_value();
		r.target = any_value();
		r.actual = any_value();
		r.drate = any_value();
		r.tstep = $urandom_range(1) ? 31'($urandom_range(0, 32'h0002_0000)) : 31'($urandom);
		r.load_w = $urandom_range(1) ? $urandom_range(0, 32'h000C_0000) : $urandom;
		pick = $urandom_range(99);
		if (pick < 35) r.fn = FN_STDP;
		else if (pick < 45) r.fn = FN_BCM;
		else if (pick < 55) r.fn = FN_HEBB;
		else if (pick < 65) r.fn = FN_ANTI;
		else if (pick < 75) r.fn = FN_HOMEO;
		else if (pick < 87) r.fn = FN_DECAY;
		else if (pick < 96) r.fn = FN_LOAD;
		else r.fn = FN_UNUSED;
		// mostly spike pairs near each other, some missing or far apart
		base = $urandom_range(0, 32'h7FFF_0000);
		r.pre_t = base;
		r.post_t = base + $urandom_range(0, 14000) - 7000;
		pick = $urandom_range(9);
		if (pick == 0) r.pre_t = $urandom | 32'h8000_0000;
		else if (pick == 1) r.post_t = $urandom | 32'h8000_0000;
		else if (pick == 2) begin
			r.pre_t = $urandom;
			r.post_t = $urandom;
		end
		return r;
	endfunction

	function automatic request_t make_request(input logic [2:0] fn,
		input logic [31:0] pt, input logic [31:0] qt,
		input logic [31:0] pa, input logic [31:0] qa);
		request_t r;
		r = '{fn, pt, qt, pa, qa, 32'h0002_0000, 32'h0001_0000,
			32'h0000_1000, 31'h0000_8000, 32'h0003_0000};
		return r;
	endfunction

	task automatic test_directed();
		request_t r;
		// spike pairs: potentiation, coincident, depression, missing, outside window
		send_request(make_request(FN_STDP, 32'h0001_0000, 32'h0001_0100, 0, 0));
		send_request(make_request(FN_STDP, 32'h0001_0000, 32'h0001_0000, 0, 0));
		send_request(make_request(FN_STDP, 32'h0001_0800, 32'h0001_0000, 0, 0));
		send_request(make_request(FN_STDP, 32'hFFFF_0000, 32'h0001_0000, 0, 0));
		send_request(make_request(FN_STDP, 32'h0001_0000, 32'h8000_0000, 0, 0));
		send_request(make_request(FN_STDP, 32'h0001_0000, 32'h0001_0000 + 6554, 0, 0));
		send_request(make_request(FN_STDP, 32'h0001_0000 + 6553, 32'h0001_0000, 0, 0));
		send_request(make_request(FN_STDP, 0, 32'h7FFF_FFFF, 0, 0));
		// activity rules at extremes
		send_request(make_request(FN_BCM, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_request(make_request(FN_BCM, 0, 0, 32'h8000_0000, 32'h8000_0000));
		send_request(make_request(FN_HEBB, 0, 0, 32'h0002_0000, 32'h0003_0000));
		send_request(make_request(FN_ANTI, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
		send_request(make_request(FN_HOMEO, 0, 0, 0, 0));
		r = make_request(FN_HOMEO, 0, 0, 0, 0);
		r.target = 32'h7FFF_FFFF;
		r.actual = 32'h8000_0000;
		send_request(r);
		// decay with positive, zero and negative rate, and a huge step
		r = make_request(FN_DECAY, 0, 0, 0, 0);
		send_request(r);
		r.drate = 0;
		send_request(r);
		r.drate = 32'h8000_0000;
		send_request(r);
		r.drate = 32'h7FFF_FFFF;
		r.tstep = 31'h7FFF_FFFF;
		send_request(r);
		// direct loads at both ends, with the unused selector between them
		r = make_request(FN_LOAD, 0, 0, 0, 0);
		r.load_w = 32'h7FFF_FFFF;
		send_request(r);
		r.fn = FN_UNUSED;
		send_request(r);
		r.fn = FN_LOAD;
		r.load_w = 32'h8000_0000;
		send_request(r);
		send_request(make_request(FN_HEBB, 0, 0, 32'h0001_0000, 32'h0001_0000));
		send_request(make_request(FN_LOAD, 0, 0, 0, 0));
		wait_drained();
	endtask

	// large tau exponent and tau of zero under the extreme register sets
	task automatic test_config_extremes();
		apply_setting(1);
		send_request(make_request(FN_STDP, 32'h0001_0000, 32'h0001_1000, 0, 0));
		send_request(make_request(FN_STDP, 32'h0001_1000, 32'h0001_0000, 0, 0));
		send_request(make_request(FN_BCM, 0, 0, 32'h0001_0000, 32'h0001_0000));
		wait_drained();
		apply_setting(2);
		send_request(make_request(FN_HEBB, 0, 0, 32'h0004_0000, 32'h0004_0000));
		send_request(make_request(FN_DECAY, 0, 0, 0, 0));
		wait_drained();
	endtask

	task automatic test_random(input int per_phase);
		int tx_set [3] = '{38, 65, 0};
		int rx_set [3] = '{65, 38, 0};
		for (int m = 0; m < 3; m++) begin
			tx_idle = tx_set[m];
			rx_idle = rx_set[m];
			for (int c = 0; c < 4; c++) begin
				apply_setting(m * 4 + c);
				repeat (per_phase) send_request(random_request());
				wait_drained();
			end
		end
	endtask

	// receiver holds off while requests keep coming, then the sender drains
	task automatic test_backpressure();
		tx_idle = 0;
		rx_idle = 0;
		apply_setting(4);
		rx_hold = 400;
		repeat (20) send_request(random_request());
		wait_drained();
		repeat (10) send_request(random_request());
		wait_drained();
	endtask

	initial begin
		fill_exp_lut();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);
		test_directed();
		test_config_extremes();
		test_random(88);
		test_backpressure();
		$display("covered %0d requests over all update rules, %0d reports checked,",
			n_sent, n_checked);
		$display("register sets at both extremes, random idling and a long output stall");
		if (errors == 0 && expected_reps.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d errors, %0d reports missing", errors, expected_reps.size());
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("timed out with %0d reports outstanding", expected_reps.size());
		$display("FAILURE");
		$finish;
	end

endmodule
